FILE: rtl/pcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcs_pkg - shared types and constants of the PC power sequencer
// Transfer payloads, control flag and pin drive encodings, register indexes,
// event codes and register reset values.
// ---------------------------------------------------------------------------
package pcs_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned RegWidth      = 16;
  localparam int unsigned NumFlags      = 14;
  localparam int unsigned NumPins       = 5;

  typedef logic [NumFlags-1:0] pcs_flags_t;
  typedef logic [NumPins-1:0]  pcs_pins_t;
  typedef logic [RegWidth-1:0] pcs_reg_t;

  // control flag bits
  localparam pcs_flags_t F_OPEN_READY     = 14'h0001;
  localparam pcs_flags_t F_CLOSE_READY    = 14'h0002;
  localparam pcs_flags_t F_OPEN_ARM       = 14'h0004;
  localparam pcs_flags_t F_HOLD_ARM       = 14'h0008;
  localparam pcs_flags_t F_CLOSE_ARM      = 14'h0010;
  localparam pcs_flags_t F_HOLD_ENOUGH    = 14'h0020;
  localparam pcs_flags_t F_CLOSING        = 14'h0040;
  localparam pcs_flags_t F_OPENING        = 14'h0080;
  localparam pcs_flags_t F_FORCE          = 14'h0100;
  localparam pcs_flags_t F_OVER_TIME      = 14'h0200;
  localparam pcs_flags_t F_KEY_DONE       = 14'h0400;
  localparam pcs_flags_t F_CLOSE_KEY_DONE = 14'h0800;
  localparam pcs_flags_t F_SETTLING       = 14'h1000;
  localparam pcs_flags_t F_SETTLE_ARM     = 14'h2000;
  localparam pcs_flags_t FLAGS_IDLE =
      F_OPEN_READY | F_OPEN_ARM | F_HOLD_ARM | F_CLOSE_ARM | F_SETTLE_ARM;

  // pin drive bits
  localparam pcs_pins_t P_EN_LOW = 5'h01;
  localparam pcs_pins_t P_KEY_OD = 5'h02;
  localparam pcs_pins_t P_BOARD  = 5'h04;
  localparam pcs_pins_t P_BATT   = 5'h08;
  localparam pcs_pins_t P_EDGE   = 5'h10;

  typedef enum logic [1:0] {
    SHUT_NONE    = 2'd0,
    SHUT_PRE_OFF = 2'd1,
    SHUT_LOCKOUT = 2'd2,
    SHUT_SPARE   = 2'd3
  } pcs_stage_t;

  typedef enum logic [2:0] {
    LOG_NONE      = 3'd0,
    LOG_POWER_REQ = 3'd1,
    LOG_OPENED    = 3'd2,
    LOG_CLOSE_REQ = 3'd3,
    LOG_CLOSE_DONE = 3'd4,
    LOG_PC_OFF    = 3'd5,
    LOG_FORCED    = 3'd6
  } pcs_log_t;

  typedef enum logic [2:0] {
    REG_SETTLE      = 3'd0,
    REG_OPEN_PULSE  = 3'd1,
    REG_HOLD        = 3'd2,
    REG_CLOSE_PULSE = 3'd3,
    REG_FORCE_OFF   = 3'd4,
    REG_PRE_OFF     = 3'd5,
    REG_LOCKOUT     = 3'd6,
    REG_UNUSED      = 3'd7
  } pcs_reg_idx_t;

  localparam pcs_reg_t SETTLE_RST      = 16'd200;
  localparam pcs_reg_t OPEN_PULSE_RST  = 16'd500;
  localparam pcs_reg_t HOLD_RST        = 16'd2000;
  localparam pcs_reg_t CLOSE_PULSE_RST = 16'd500;
  localparam pcs_reg_t FORCE_OFF_RST   = 16'd40000;
  localparam pcs_reg_t PRE_OFF_RST     = 16'd1000;
  localparam pcs_reg_t LOCKOUT_RST     = 16'd500;

  typedef struct packed {
    pcs_reg_t settle_ticks;
    pcs_reg_t open_pulse_ticks;
    pcs_reg_t hold_ticks;
    pcs_reg_t close_pulse_ticks;
    pcs_reg_t force_off_ticks;
    pcs_reg_t pre_off_ticks;
    pcs_reg_t lockout_ticks;
  } pcs_cfg_t;

  // fixed-width control state carried between the registers and the step logic
  typedef struct packed {
    pcs_flags_t  flags;
    pcs_stage_t  stage;
    logic [15:0] boots;
    pcs_pins_t   pins;
  } pcs_ctrl_t;

  typedef struct packed {
    logic key_level;
    logic pc_off_level;
  } pcs_in_t;

  typedef struct packed {
    logic        enable_pulled_low;
    logic        key_open_drain;
    logic        board_power_on;
    logic        battery_on;
    logic        edge_irq_enable;
    logic [2:0]  log_code;
    logic [15:0] boot_count;
  } pcs_out_t;

endpackage
`default_nettype wire

FILE: rtl/pcs_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcs_step - next-state logic for one millisecond tick
// Given the current sequencer state, the register file and one sampled input,
// produces the state after the tick and the event code of that tick.
// ---------------------------------------------------------------------------
module pcs_step #(
  parameter int unsigned COUNT_WIDTH = pcs_pkg::CountWidthDef
) (
  input  pcs_pkg::pcs_cfg_t      cfg,
  input  pcs_pkg::pcs_in_t       din,
  input  pcs_pkg::pcs_ctrl_t     ctrl_cur,
  input  logic [COUNT_WIDTH-1:0] settle_cur,
  input  logic [COUNT_WIDTH-1:0] open_cur,
  input  logic [COUNT_WIDTH-1:0] hold_cur,
  input  logic [COUNT_WIDTH-1:0] close_cur,
  input  logic [COUNT_WIDTH-1:0] force_cur,
  input  logic [COUNT_WIDTH-1:0] shut_cur,
  output pcs_pkg::pcs_ctrl_t     ctrl_nxt,
  output logic [COUNT_WIDTH-1:0] settle_nxt,
  output logic [COUNT_WIDTH-1:0] open_nxt,
  output logic [COUNT_WIDTH-1:0] hold_nxt,
  output logic [COUNT_WIDTH-1:0] close_nxt,
  output logic [COUNT_WIDTH-1:0] force_nxt,
  output logic [COUNT_WIDTH-1:0] shut_nxt,
  output pcs_pkg::pcs_log_t      log_nxt
);
  import pcs_pkg::*;

  localparam int unsigned CmpWidth = (COUNT_WIDTH > RegWidth) ? COUNT_WIDTH : RegWidth;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // saturating increment
  function automatic cnt_t bump(input cnt_t c);
    return (c == {COUNT_WIDTH{1'b1}}) ? c : c + cnt_t'(1);
  endfunction

  function automatic logic reached(input cnt_t c, input pcs_reg_t lim);
    return CmpWidth'(c) >= CmpWidth'(lim);
  endfunction

  pcs_flags_t f;
  pcs_pins_t  p;
  pcs_stage_t st;
  logic [15:0] bt;
  cnt_t       c_set, c_opn, c_hld, c_cls, c_frc, c_sh;
  pcs_log_t   lg;
  logic       adv;
  logic       key, pc_off;

  always_comb begin
    f      = ctrl_cur.flags;
    p      = ctrl_cur.pins;
    st     = ctrl_cur.stage;
    bt     = ctrl_cur.boots;
    c_set  = settle_cur;
    c_opn  = open_cur;
    c_hld  = hold_cur;
    c_cls  = close_cur;
    c_frc  = force_cur;
    c_sh   = shut_cur;
    lg     = LOG_NONE;
    adv    = 1'b0;
    key    = din.key_level;
    pc_off = din.pc_off_level;

    if (st != SHUT_NONE) begin
      // inputs are ignored while shutting down
      c_sh = bump(c_sh);
      adv  = 1'b1;
    end else begin
      if ((f & F_OPEN_READY) != '0) begin
        p = p | P_EDGE;
        if (key && ((f & F_KEY_DONE) == '0)) begin
          p = (p & ~P_KEY_OD) | P_BOARD | P_BATT;
          f = f | F_SETTLING | F_KEY_DONE;
        end
        if ((f & F_SETTLING) != '0) begin
          if ((f & F_SETTLE_ARM) != '0) begin
            lg    = LOG_POWER_REQ;
            c_set = '0;
            f     = f & ~F_SETTLE_ARM;
          end else begin
            c_set = bump(c_set);
          end
          if (reached(c_set, cfg.settle_ticks)) begin
            p = (p | P_KEY_OD) & ~P_EN_LOW;
            f = (f & ~F_SETTLING) | F_OPENING;
          end
        end
        if ((f & F_OPENING) != '0) begin
          p = p | P_EN_LOW;
          if ((f & F_OPEN_ARM) != '0) begin
            c_opn = '0;
            f     = f & ~F_OPEN_ARM;
          end else begin
            c_opn = bump(c_opn);
          end
          if (reached(c_opn, cfg.open_pulse_ticks)) begin
            bt = bt + 16'd1;
            p  = p & ~P_EN_LOW;
            f  = (f & ~(F_OPENING | F_OPEN_READY)) | F_OPEN_ARM | F_CLOSE_READY;
            lg = LOG_OPENED;
          end
        end
      end

      if ((f & F_CLOSE_READY) != '0) begin
        if ((f & F_FORCE) != '0) begin
          c_frc = bump(c_frc);
        end
        if (pc_off) begin
          p    = p & ~P_EDGE;
          lg   = LOG_PC_OFF;
          st   = SHUT_PRE_OFF;
          c_sh = '0;
          adv  = 1'b1;
        end else begin
          if (key && ((f & F_HOLD_ENOUGH) == '0)) begin
            if ((f & F_HOLD_ARM) != '0) begin
              c_hld = '0;
              f     = f & ~F_HOLD_ARM;
            end else begin
              c_hld = bump(c_hld);
            end
            if (reached(c_hld, cfg.hold_ticks)) begin
              f = f | F_HOLD_ARM | F_OVER_TIME;
            end
          end else if (!key) begin
            f = (f | F_HOLD_ARM) & ~F_HOLD_ENOUGH;
          end
          // long press released: request close
          if (((f & F_OVER_TIME) != '0) && !key && ((f & F_CLOSE_KEY_DONE) == '0)) begin
            f     = f | F_HOLD_ENOUGH | F_CLOSING | F_FORCE | F_CLOSE_KEY_DONE;
            c_frc = '0;
            p     = p & ~P_EDGE;
            lg    = LOG_CLOSE_REQ;
          end
          if ((f & F_CLOSING) != '0) begin
            p = p | P_EN_LOW;
            if ((f & F_CLOSE_ARM) != '0) begin
              c_cls = '0;
              f     = f & ~F_CLOSE_ARM;
            end else begin
              c_cls = bump(c_cls);
            end
            if (reached(c_cls, cfg.close_pulse_ticks)) begin
              p  = p & ~P_EN_LOW;
              f  = (f & ~F_CLOSING) | F_CLOSE_ARM;
              lg = LOG_CLOSE_DONE;
            end
          end
          if (((f & F_FORCE) != '0) && reached(c_frc, cfg.force_off_ticks)) begin
            lg   = LOG_FORCED;
            st   = SHUT_PRE_OFF;
            c_sh = '0;
            adv  = 1'b1;
          end
        end
      end
    end

    if (adv) begin
      if ((st == SHUT_PRE_OFF) && reached(c_sh, cfg.pre_off_ticks)) begin
        p    = p & ~(P_KEY_OD | P_BOARD | P_BATT);
        st   = SHUT_LOCKOUT;
        c_sh = '0;
      end
      if ((st == SHUT_LOCKOUT) && reached(c_sh, cfg.lockout_ticks)) begin
        f  = FLAGS_IDLE;
        st = SHUT_NONE;
      end
      if (st == SHUT_SPARE) begin
        f  = FLAGS_IDLE;
        st = SHUT_NONE;
      end
    end
  end

  assign ctrl_nxt.flags = f;
  assign ctrl_nxt.stage = st;
  assign ctrl_nxt.boots = bt;
  assign ctrl_nxt.pins  = p;
  assign settle_nxt     = c_set;
  assign open_nxt       = c_opn;
  assign hold_nxt       = c_hld;
  assign close_nxt      = c_cls;
  assign force_nxt      = c_frc;
  assign shut_nxt       = c_sh;
  assign log_nxt        = lg;

endmodule
`default_nettype wire

FILE: rtl/pc_power_on_off_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pc_power_on_off_sequencer - key driven PC power on/off sequencer
// One input transfer is one millisecond tick; each tick yields one result
// carrying pin drive levels, the tick's event code and the boot count.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   pcs_in_t  (key, pc-off pins)
//   out_     output     out_valid / out_ready pcs_out_t (pins, event, boots)
//   cfg_     input      cfg_valid / cfg_ready cfg_index (3b), cfg_data (16b)
//
// One tick per clock unless a held result stalls it: state is updated at the
// input transfer, the result appears in the output register on the next cycle.
// in_ready stays high while the output register is empty or being drained,
// so a stalled consumer holds at most one result.
// Synchronous active-low reset restores idle state and register defaults.
// cfg_ready is always high; indexes beyond the last register are dropped.
// ---------------------------------------------------------------------------
module pc_power_on_off_sequencer #(
  parameter int unsigned COUNT_WIDTH = pcs_pkg::CountWidthDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcs_pkg::pcs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pcs_pkg::pcs_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import pcs_pkg::*;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  pcs_cfg_t  cfg_r, cfg_nxt;
  pcs_ctrl_t ctrl_r, ctrl_nxt;
  cnt_t      settle_r, open_r, hold_r, close_r, force_r, shut_r;
  cnt_t      settle_nxt, open_nxt, hold_nxt, close_nxt, force_nxt, shut_nxt;
  pcs_log_t  log_nxt;
  logic      out_valid_r, out_valid_nxt;
  pcs_out_t  out_data_r, out_data_nxt;
  logic      in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (pcs_reg_idx_t'(cfg_index))
        REG_SETTLE:      cfg_nxt.settle_ticks      = cfg_data;
        REG_OPEN_PULSE:  cfg_nxt.open_pulse_ticks  = cfg_data;
        REG_HOLD:        cfg_nxt.hold_ticks        = cfg_data;
        REG_CLOSE_PULSE: cfg_nxt.close_pulse_ticks = cfg_data;
        REG_FORCE_OFF:   cfg_nxt.force_off_ticks   = cfg_data;
        REG_PRE_OFF:     cfg_nxt.pre_off_ticks     = cfg_data;
        REG_LOCKOUT:     cfg_nxt.lockout_ticks     = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  pcs_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .cfg        (cfg_r),
    .din        (in_data),
    .ctrl_cur   (ctrl_r),
    .settle_cur (settle_r),
    .open_cur   (open_r),
    .hold_cur   (hold_r),
    .close_cur  (close_r),
    .force_cur  (force_r),
    .shut_cur   (shut_r),
    .ctrl_nxt   (ctrl_nxt),
    .settle_nxt (settle_nxt),
    .open_nxt   (open_nxt),
    .hold_nxt   (hold_nxt),
    .close_nxt  (close_nxt),
    .force_nxt  (force_nxt),
    .shut_nxt   (shut_nxt),
    .log_nxt    (log_nxt)
  );

  always_comb begin
    out_data_nxt.enable_pulled_low = (ctrl_nxt.pins & P_EN_LOW) != '0;
    out_data_nxt.key_open_drain    = (ctrl_nxt.pins & P_KEY_OD) != '0;
    out_data_nxt.board_power_on    = (ctrl_nxt.pins & P_BOARD) != '0;
    out_data_nxt.battery_on        = (ctrl_nxt.pins & P_BATT) != '0;
    out_data_nxt.edge_irq_enable   = (ctrl_nxt.pins & P_EDGE) != '0;
    out_data_nxt.log_code          = log_nxt;
    out_data_nxt.boot_count        = ctrl_nxt.boots;
  end

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks      <= SETTLE_RST;
      cfg_r.open_pulse_ticks  <= OPEN_PULSE_RST;
      cfg_r.hold_ticks        <= HOLD_RST;
      cfg_r.close_pulse_ticks <= CLOSE_PULSE_RST;
      cfg_r.force_off_ticks   <= FORCE_OFF_RST;
      cfg_r.pre_off_ticks     <= PRE_OFF_RST;
      cfg_r.lockout_ticks     <= LOCKOUT_RST;
      ctrl_r.flags            <= FLAGS_IDLE;
      ctrl_r.stage            <= SHUT_NONE;
      ctrl_r.boots            <= '0;
      ctrl_r.pins             <= '0;
      settle_r                <= '0;
      open_r                  <= '0;
      hold_r                  <= '0;
      close_r                 <= '0;
      force_r                 <= '0;
      shut_r                  <= '0;
      out_valid_r             <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        ctrl_r   <= ctrl_nxt;
        settle_r <= settle_nxt;
        open_r   <= open_nxt;
        hold_r   <= hold_nxt;
        close_r  <= close_nxt;
        force_r  <= force_nxt;
        shut_r   <= shut_nxt;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - PC power on/off sequencer check
// Feeds millisecond ticks with random key and pc-off levels through the input
// channel, mostly as complete power cycles, under several timing register
// settings. A cycle accurate software copy of the sequencer predicts every
// result, which is compared field by field as the results drain with random
// back-pressure.
// ---------------------------------------------------------------------------
module testbench;
  import pcs_pkg::*;

  localparam int unsigned COUNT_MAX   = (32'd1 << CountWidthDef) - 1;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // timer slots of the software copy
  localparam int TMR_SETTLE = 0;
  localparam int TMR_OPEN   = 1;
  localparam int TMR_HOLD   = 2;
  localparam int TMR_CLOSE  = 3;
  localparam int TMR_FORCE  = 4;
  localparam int TMR_SHUT   = 5;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pcs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pcs_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pc_power_on_off_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // software copy of the sequencer state
  pcs_cfg_t    timing = {SETTLE_RST, OPEN_PULSE_RST, HOLD_RST, CLOSE_PULSE_RST,
                         FORCE_OFF_RST, PRE_OFF_RST, LOCKOUT_RST};
  pcs_flags_t  flags = FLAGS_IDLE;
  pcs_stage_t  stage = SHUT_NONE;
  pcs_pins_t   pins = '0;
  logic [15:0] boots = '0;
  int unsigned tmr [6];
  pcs_log_t    tick_event;

  pcs_in_t  pending_ticks [$];
  pcs_out_t predicted_drive_q [$];
  pcs_reg_t reg_plan [8];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  function automatic int unsigned sat_inc(int unsigned c);
    return (c < COUNT_MAX) ? c + 1 : COUNT_MAX;
  endfunction

  // restart on the arming tick, count up on later ones
  function automatic bit timer_done(int idx, pcs_flags_t arm, pcs_reg_t lim);
    if ((flags & arm) != 0) begin
      tmr[idx] = 0;
      flags = flags & ~arm;
    end else begin
      tmr[idx] = sat_inc(tmr[idx]);
    end
    return tmr[idx] >= lim;
  endfunction

  function automatic void stage_advance();
    if (stage == SHUT_PRE_OFF && tmr[TMR_SHUT] >= timing.pre_off_ticks) begin
      pins = pins & ~(P_KEY_OD | P_BOARD | P_BATT);
      stage = SHUT_LOCKOUT;
      tmr[TMR_SHUT] = 0;
    end
    if (stage == SHUT_LOCKOUT && tmr[TMR_SHUT] >= timing.lockout_ticks) begin
      flags = FLAGS_IDLE;
      stage = SHUT_NONE;
    end
    if (stage == SHUT_SPARE) begin
      flags = FLAGS_IDLE;
      stage = SHUT_NONE;
    end
  endfunction

  function automatic void start_shutdown();
    stage = SHUT_PRE_OFF;
    tmr[TMR_SHUT] = 0;
    stage_advance();
  endfunction

  function automatic void run_tick(logic key, logic pc_off);
    if (stage != SHUT_NONE) begin
      tmr[TMR_SHUT] = sat_inc(tmr[TMR_SHUT]);
      stage_advance();
      return;
    end
    if ((flags & F_OPEN_READY) != 0) begin
      pins = pins | P_EDGE;
      if (key && (flags & F_KEY_DONE) == 0) begin
        pins = (pins & ~P_KEY_OD) | P_BOARD | P_BATT;
        flags = flags | F_SETTLING | F_KEY_DONE;
      end
      if ((flags & F_SETTLING) != 0) begin
        if ((flags & F_SETTLE_ARM) != 0) tick_event = LOG_POWER_REQ;
        if (timer_done(TMR_SETTLE, F_SETTLE_ARM, timing.settle_ticks)) begin
          pins = (pins | P_KEY_OD) & ~P_EN_LOW;
          flags = (flags & ~F_SETTLING) | F_OPENING;
        end
      end
      if ((flags & F_OPENING) != 0) begin
        pins = pins | P_EN_LOW;
        if (timer_done(TMR_OPEN, F_OPEN_ARM, timing.open_pulse_ticks)) begin
          boots = boots + 16'd1;
          pins = pins & ~P_EN_LOW;
          flags = (flags & ~(F_OPENING | F_OPEN_READY)) | F_OPEN_ARM | F_CLOSE_READY;
          tick_event = LOG_OPENED;
        end
      end
    end
    if ((flags & F_CLOSE_READY) != 0) begin
      if ((flags & F_FORCE) != 0) tmr[TMR_FORCE] = sat_inc(tmr[TMR_FORCE]);
      if (pc_off) begin
        pins = pins & ~P_EDGE;
        tick_event = LOG_PC_OFF;
        start_shutdown();
        return;
      end
      if (key && (flags & F_HOLD_ENOUGH) == 0) begin
        if (timer_done(TMR_HOLD, F_HOLD_ARM, timing.hold_ticks))
          flags = flags | F_HOLD_ARM | F_OVER_TIME;
      end else if (!key) begin
        flags = (flags | F_HOLD_ARM) & ~F_HOLD_ENOUGH;
      end
      if ((flags & F_OVER_TIME) != 0 && !key && (flags & F_CLOSE_KEY_DONE) == 0) begin
        flags = flags | F_HOLD_ENOUGH | F_CLOSING | F_FORCE | F_CLOSE_KEY_DONE;
        tmr[TMR_FORCE] = 0;
        pins = pins & ~P_EDGE;
        tick_event = LOG_CLOSE_REQ;
      end
      if ((flags & F_CLOSING) != 0) begin
        pins = pins | P_EN_LOW;
        if (timer_done(TMR_CLOSE, F_CLOSE_ARM, timing.close_pulse_ticks)) begin
          pins = pins & ~P_EN_LOW;
          flags = (flags & ~F_CLOSING) | F_CLOSE_ARM;
          tick_event = LOG_CLOSE_DONE;
        end
      end
      if ((flags & F_FORCE) != 0 && tmr[TMR_FORCE] >= timing.force_off_ticks) begin
        tick_event = LOG_FORCED;
        start_shutdown();
        return;
      end
    end
  endfunction

  function automatic void sequencer_tick(pcs_in_t t);
    pcs_out_t r;
    tick_event = LOG_NONE;
    run_tick(t.key_level, t.pc_off_level);
    r.enable_pulled_low = (pins & P_EN_LOW) != 0;
    r.key_open_drain    = (pins & P_KEY_OD) != 0;
    r.board_power_on    = (pins & P_BOARD) != 0;
    r.battery_on        = (pins & P_BATT) != 0;
    r.edge_irq_enable   = (pins & P_EDGE) != 0;
    r.log_code          = tick_event;
    r.boot_count        = boots;
    predicted_drive_q.push_back(r);
  endfunction

  function automatic int unsigned idle_draw(bit calm);
    return calm ? 0 : $urandom_range(5, 0);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // tick source
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) sequencer_tick(in_data);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          in_data <= pending_ticks.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(39, 0) == 0) send_calm = !send_calm;
          send_gap = idle_draw(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result sink
  always @(posedge clk) begin
    pcs_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_drive_q.size() == 0) begin
          $error("result transfer with nothing predicted");
          mismatches++;
        end else begin
          want = predicted_drive_q.pop_front();
          check_field("enable_pulled_low", 32'(want.enable_pulled_low),
                      32'(out_data.enable_pulled_low));
          check_field("key_open_drain", 32'(want.key_open_drain),
                      32'(out_data.key_open_drain));
          check_field("board_power_on", 32'(want.board_power_on),
                      32'(out_data.board_power_on));
          check_field("battery_on", 32'(want.battery_on), 32'(out_data.battery_on));
          check_field("edge_irq_enable", 32'(want.edge_irq_enable),
                      32'(out_data.edge_irq_enable));
          check_field("log_code", 32'(want.log_code), 32'(out_data.log_code));
          check_field("boot_count", 32'(want.boot_count), 32'(out_data.boot_count));
        end
        if ($urandom_range(39, 0) == 0) recv_calm = !recv_calm;
        recv_stall = idle_draw(recv_calm);
      end else if (recv_stall != 0) begin
        recv_stall--;
      end
      out_ready <= (recv_stall == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_ticks(int n, bit key, bit pc_off, bit scramble);
    pcs_in_t t;
    for (int i = 0; i < n; i++) begin
      t.key_level    = scramble ? 1'($urandom_range(1, 0)) : key;
      t.pc_off_level = scramble ? 1'($urandom_range(1, 0)) : pc_off;
      pending_ticks.push_back(t);
    end
  endtask

  // press, boot, up to two key taps, then a close by pc-off or by the hold path
  task automatic queue_power_cycle();
    int taps;
    taps = $urandom_range(2, 0);
    queue_ticks($urandom_range(3, 0), 1'b0, 1'b0, 1'b0);
    queue_ticks($urandom_range(3, 1), 1'b1, 1'b0, 1'b0);
    queue_ticks(timing.settle_ticks + timing.open_pulse_ticks + $urandom_range(3, 1),
                1'b0, 1'b0, 1'b0);
    repeat (taps) begin
      queue_ticks($urandom_range(timing.hold_ticks, 1), 1'b1, 1'b0, 1'b0);
      queue_ticks($urandom_range(3, 1), 1'b0, 1'b0, 1'b0);
    end
    if ($urandom_range(9, 0) < 3) begin
      queue_ticks(1, 1'b0, 1'b1, 1'b0);
    end else begin
      queue_ticks(timing.hold_ticks + $urandom_range(2, 1), 1'b1, 1'b0, 1'b0);
      if ($urandom_range(1, 0) == 0) begin
        queue_ticks($urandom_range(timing.close_pulse_ticks + 3, 0), 1'b0, 1'b0, 1'b0);
        queue_ticks(1, 1'b0, 1'b1, 1'b0);
      end else begin
        queue_ticks(timing.force_off_ticks + 2, 1'b0, 1'b0, 1'b0);
      end
    end
    // inputs are ignored while shutting down
    queue_ticks(timing.pre_off_ticks + timing.lockout_ticks + 2, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic load_timing();
    pcs_reg_idx_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = pcs_reg_idx_t'(i);
      cfg_index <= idx;
      cfg_data <= reg_plan[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        REG_SETTLE:      timing.settle_ticks = reg_plan[i];
        REG_OPEN_PULSE:  timing.open_pulse_ticks = reg_plan[i];
        REG_HOLD:        timing.hold_ticks = reg_plan[i];
        REG_CLOSE_PULSE: timing.close_pulse_ticks = reg_plan[i];
        REG_FORCE_OFF:   timing.force_off_ticks = reg_plan[i];
        REG_PRE_OFF:     timing.pre_off_ticks = reg_plan[i];
        REG_LOCKOUT:     timing.lockout_ticks = reg_plan[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_ticks.size() != 0 || in_valid || predicted_drive_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing: key press starts power-up, pc-off is ignored meanwhile
    queue_ticks(1, 1'b0, 1'b0, 1'b0);
    queue_ticks(1, 1'b1, 1'b1, 1'b0);
    queue_ticks(1, 1'b1, 1'b0, 1'b0);
    queue_ticks(1, 1'b0, 1'b1, 1'b0);
    queue_ticks(1, 1'b0, 1'b0, 1'b0);
    wait_idle();

    // shortest timing, zero shutdown delays collapse into one tick
    reg_plan[REG_SETTLE]      = 16'd1;
    reg_plan[REG_OPEN_PULSE]  = 16'd1;
    reg_plan[REG_HOLD]        = 16'd1;
    reg_plan[REG_CLOSE_PULSE] = 16'd1;
    reg_plan[REG_FORCE_OFF]   = 16'd1;
    reg_plan[REG_PRE_OFF]     = 16'd0;
    reg_plan[REG_LOCKOUT]     = 16'd0;
    reg_plan[REG_UNUSED]      = 16'hffff;
    load_timing();
    queue_ticks(3, 1'b0, 1'b0, 1'b0);
    queue_ticks(3, 1'b1, 1'b0, 1'b0);
    queue_ticks(4, 1'b0, 1'b0, 1'b0);
    queue_ticks(1, 1'b1, 1'b0, 1'b0);
    queue_ticks(4, 1'b0, 1'b0, 1'b0);
    queue_ticks(1, 1'b0, 1'b1, 1'b0);
    queue_ticks(1, 1'b1, 1'b1, 1'b0);
    queue_ticks(4, 1'b0, 1'b0, 1'b0);
    queue_ticks(3, 1'b1, 1'b0, 1'b0);
    queue_ticks(1, 1'b0, 1'b1, 1'b0);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      if (p == 4) begin
        // longest timing everywhere, only a short noisy stretch
        for (int i = 0; i < 7; i++) reg_plan[i] = 16'hffff;
        reg_plan[REG_UNUSED] = 16'($urandom);
        load_timing();
        queue_ticks(40, 1'b0, 1'b0, 1'b1);
      end else begin
        reg_plan[REG_SETTLE]      = 16'($urandom_range(8, 1));
        reg_plan[REG_OPEN_PULSE]  = 16'($urandom_range(8, 1));
        reg_plan[REG_HOLD]        = 16'($urandom_range(10, 1));
        reg_plan[REG_CLOSE_PULSE] = 16'($urandom_range(8, 1));
        reg_plan[REG_FORCE_OFF]   = 16'($urandom_range(30, 1));
        reg_plan[REG_PRE_OFF]     = 16'($urandom_range(6, 0));
        reg_plan[REG_LOCKOUT]     = 16'($urandom_range(6, 0));
        reg_plan[REG_UNUSED]      = 16'($urandom);
        load_timing();
        while (pending_ticks.size() < 180) begin
          if ($urandom_range(4, 0) != 0) queue_power_cycle();
          else queue_ticks($urandom_range(8, 1), 1'b0, 1'b0, 1'b1);
        end
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
